### sv/nwss_pkg.sv
`default_nettype none

package nwss_pkg;

  // configuration port geometry
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 3;
  localparam int WP_REGS   = 4;

  // register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_WAYPOINT_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WAYPOINT_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYPOINT_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WAYPOINT_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COUNT      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_PROXIMITY  = 3'd5;

  // register reset values and the minimum waypoint count
  localparam logic [2:0]  COUNT_RESET   = 3'd4;
  localparam logic [19:0] PROX_RESET    = 20'd2000;
  localparam logic [39:0] PROX_SQ_RESET = 40'd4000000;
  localparam logic [2:0]  COUNT_MIN     = 3'd2;

  typedef logic [1:0]  wp_idx_t;
  typedef logic [31:0] mag_t;
  typedef logic [63:0] square_t;
  typedef logic [64:0] dist_t;
  typedef logic [63:0] waypoint_t;

endpackage

`default_nettype wire

### sv/nearest_waypoint_segment_select.sv
// pipeline: an accepted request passes the input, squaring, summing and selection stages in order
// throughput: one request per cycle while out_ready holds; these stages
// each hold one request, and a stalled result does not stop upstream stages that are empty
// reset: synchronous active-high rst clears all stage valids, the segment to 0..1,
// the arrival flag, and the configuration registers to their reset values
`default_nettype none

module nearest_waypoint_segment_select #(
  parameter int MAX_WAYPOINTS = 4
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // fix channel
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  signed [30:0]                  fix_latitude,
  input  wire  signed [31:0]                  fix_longitude,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [1:0]                          nearest_index,
  output logic [1:0]                          segment_start,
  output logic [1:0]                          segment_goal,
  output logic                                arrived,
  // configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [nwss_pkg::ADDR_W-1:0]         paddr,
  input  wire  [nwss_pkg::DATA_W-1:0]         pwdata,
  output logic [nwss_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int LIMIT = (MAX_WAYPOINTS < nwss_pkg::WP_REGS) ? MAX_WAYPOINTS
                                                             : nwss_pkg::WP_REGS;
  localparam logic [2:0] LIMIT_CNT = 3'(LIMIT);

  // configuration registers
  nwss_pkg::waypoint_t waypoint [nwss_pkg::WP_REGS];
  logic [2:0]          waypoint_count;
  logic [19:0]         proximity;
  logic [39:0]         prox_sq;

  // segment state
  nwss_pkg::wp_idx_t start_sel;
  nwss_pkg::wp_idx_t goal_sel;
  logic              goal_reached;

  // pipeline stages
  logic                 v1, v2, v3;
  logic signed [30:0]   lat1;
  logic signed [31:0]   lon1;
  nwss_pkg::square_t    sq_lat [nwss_pkg::WP_REGS];
  nwss_pkg::square_t    sq_lon [nwss_pkg::WP_REGS];
  nwss_pkg::dist_t      dist3  [nwss_pkg::WP_REGS];
  nwss_pkg::wp_idx_t    nearest;

  logic rdy2, rdy3, rdy4;

  logic [nwss_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_write;

  assign reg_idx   = paddr[nwss_pkg::ADDR_W-1:3];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nwss_pkg::WP_REGS; i++) begin
        waypoint[i] <= '0;
      end
      waypoint_count <= nwss_pkg::COUNT_RESET;
      proximity      <= nwss_pkg::PROX_RESET;
      prox_sq        <= nwss_pkg::PROX_SQ_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx) inside
        nwss_pkg::REG_WAYPOINT_0, nwss_pkg::REG_WAYPOINT_1,
        nwss_pkg::REG_WAYPOINT_2, nwss_pkg::REG_WAYPOINT_3: begin
          waypoint[reg_idx[1:0]] <= pwdata;
        end
        nwss_pkg::REG_COUNT: begin
          waypoint_count <= pwdata[2:0];
        end
        nwss_pkg::REG_PROXIMITY: begin
          proximity <= pwdata[19:0];
          prox_sq   <= 40'(pwdata[19:0]) * 40'(pwdata[19:0]);
        end
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx) inside
      nwss_pkg::REG_WAYPOINT_0, nwss_pkg::REG_WAYPOINT_1,
      nwss_pkg::REG_WAYPOINT_2, nwss_pkg::REG_WAYPOINT_3: prdata = waypoint[reg_idx[1:0]];
      nwss_pkg::REG_COUNT:     prdata = {61'd0, waypoint_count};
      nwss_pkg::REG_PROXIMITY: prdata = {44'd0, proximity};
      default:                 prdata = '0;
    endcase
  end

  // stage handshake: a stage loads when it is empty or its contents move on
  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_valid && in_ready) begin
      lat1 <= fix_latitude;
      lon1 <= fix_longitude;
    end
  end

  // per-waypoint absolute differences, squared
  nwss_pkg::mag_t ax [nwss_pkg::WP_REGS];
  nwss_pkg::mag_t ay [nwss_pkg::WP_REGS];

  always_comb begin
    logic [32:0] dx;
    logic [32:0] dy;
    for (int i = 0; i < nwss_pkg::WP_REGS; i++) begin
      dx = {waypoint[i][63], waypoint[i][63:32]} - {{2{lat1[30]}}, lat1};
      dy = {waypoint[i][31], waypoint[i][31:0]} - {lon1[31], lon1};
      ax[i] = dx[32] ? 32'(-dx) : dx[31:0];
      ay[i] = dy[32] ? 32'(-dy) : dy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      for (int i = 0; i < nwss_pkg::WP_REGS; i++) begin
        sq_lat[i] <= 64'(ax[i]) * 64'(ax[i]);
        sq_lon[i] <= 64'(ay[i]) * 64'(ay[i]);
      end
    end
  end

  // exact 65-bit squared distances
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      for (int i = 0; i < nwss_pkg::WP_REGS; i++) begin
        dist3[i] <= {1'b0, sq_lat[i]} + {1'b0, sq_lon[i]};
      end
    end
  end

  // waypoints in use, clamped to the legal range
  logic [2:0]        cnt_used;
  nwss_pkg::wp_idx_t last_idx;

  always_comb begin
    if (waypoint_count < nwss_pkg::COUNT_MIN) begin
      cnt_used = nwss_pkg::COUNT_MIN;
    end else if (waypoint_count > LIMIT_CNT) begin
      cnt_used = LIMIT_CNT;
    end else begin
      cnt_used = waypoint_count;
    end
    last_idx = 2'(cnt_used - 3'd1);
  end

  // nearest search, earliest wins on a tie
  nwss_pkg::dist_t best_d;
  logic            far_away;
  logic            inside_r;

  always_comb begin
    nearest = '0;
    best_d  = dist3[0];
    for (int i = 1; i < nwss_pkg::WP_REGS; i++) begin
      if ((3'(i) < cnt_used) && (dist3[i] < best_d)) begin
        nearest = 2'(i);
        best_d  = dist3[i];
      end
    end
    far_away = best_d > {25'd0, prox_sq};
    inside_r = best_d < {25'd0, prox_sq};
  end

  // segment selection
  nwss_pkg::wp_idx_t start_next;
  nwss_pkg::wp_idx_t goal_next;
  logic              goal_reached_next;

  always_comb begin
    start_next        = start_sel;
    goal_next         = goal_sel;
    goal_reached_next = goal_reached;
    if (nearest == 2'd0) begin
      start_next = 2'd0;
      goal_next  = 2'd1;
    end else if (far_away) begin
      start_next = nearest - 2'd1;
      goal_next  = nearest;
    end else if (nearest != last_idx) begin
      start_next = nearest;
      goal_next  = nearest + 2'd1;
    end
    if ((nearest == last_idx) && inside_r) begin
      goal_reached_next = 1'b1;
    end
  end

  // result register, state moves with it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      start_sel    <= 2'd0;
      goal_sel     <= 2'd1;
      goal_reached <= 1'b0;
    end else begin
      if (rdy4) begin
        out_valid <= v3;
      end
      if (rdy4 && v3) begin
        start_sel    <= start_next;
        goal_sel     <= goal_next;
        goal_reached <= goal_reached_next;
      end
    end
    if (rdy4 && v3) begin
      nearest_index <= nearest;
    end
  end

  assign segment_start = start_sel;
  assign segment_goal  = goal_sel;
  assign arrived       = goal_reached;

  // arrival flag is sticky until reset
  a_arrived_sticky: assert property (@(posedge clk) disable iff (rst)
    arrived |=> arrived)
    else $error("arrival flag cleared without reset");

  // segment always spans two consecutive waypoints
  a_segment_adjacent: assert property (@(posedge clk) disable iff (rst)
    segment_goal == segment_start + 2'd1)
    else $error("segment goal is not next to its start");

  // a request leaving the distance stage becomes a result
  a_stage_to_result: assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4) |=> out_valid)
    else $error("result lost between distance stage and output");

endmodule

`default_nettype wire
